FILE: src/hkrf_pkg.sv
// Shared types and constants for the key report framer.
package hkrf_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int NUM_SLOTS   = 6;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int SLOT_W      = $clog2(NUM_SLOTS);

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] SYNC_A   = 8'hFA;
	localparam logic [7:0] SYNC_B   = 8'hFB;
	localparam logic [7:0] TRAILER  = 8'hFE;

	// Byte positions within the frame
	localparam logic [IDX_W-1:0] IDX_SYNC_A  = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_SYNC_B  = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_MOD     = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_RSVD    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_SLOT0   = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_TRAILER = IDX_W'(FRAME_BYTES - 2);
	localparam logic [IDX_W-1:0] IDX_CRC     = IDX_W'(FRAME_BYTES - 1);

	typedef struct packed {
		logic             capture;
		logic             update;
		logic             crc_clr;
		logic             load;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic frame_needed;
		logic out_free;
	} status_t;

endpackage

FILE: src/hkrf_ctrl.sv
// Controller: event sequencing and frame byte counter.
module hkrf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hkrf_pkg::status_t status,
	output hkrf_pkg::cmd_t   cmd
);
	import hkrf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_CHECK,
		ST_SEND
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             load;

	assign in_stall = (state_q != ST_IDLE);
	assign load     = (state_q == ST_SEND) && status.out_free;

	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.update  = (state_q == ST_UPDATE);
		cmd.crc_clr = (state_q == ST_CHECK);
		cmd.load    = load;
		cmd.idx     = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					idx_q <= '0;
					if (status.frame_needed) begin
						state_q <= ST_SEND;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEND: begin
					if (load) begin
						if (idx_q == IDX_CRC) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> idx_q <= IDX_CRC)
		else $error("frame byte counter out of range");

	a_crc_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q == IDX_CRC) |=> (state_q == ST_IDLE && idx_q == '0))
		else $error("frame did not end after crc byte");

	a_update_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_UPDATE) ##1 (state_q == ST_CHECK))
		else $error("event not applied before gate check");

	a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && idx_q != '0) |-> $past(state_q) == ST_SEND)
		else $error("frame interrupted");

endmodule

FILE: src/hkrf_dp.sv
// Datapath: report state, event apply, frame byte select and CRC-8.
module hkrf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             is_modifier,
	input  logic [2:0]       modifier_bit,
	input  logic [7:0]       usage,
	input  logic             pressed,
	input  logic             out_stall,
	input  hkrf_pkg::cmd_t   cmd,
	output hkrf_pkg::status_t status,
	output logic             out_valid,
	output logic [7:0]       frame_byte,
	output logic             last
);
	import hkrf_pkg::*;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// Captured event
	logic       is_mod_q;
	logic [2:0] bit_q;
	logic [7:0] usage_q;
	logic       pressed_q;

	// Report state
	logic [7:0] mod_q;
	logic [7:0] slots_q [NUM_SLOTS];

	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [7:0] frame_byte_q;
	logic       last_q;

	logic [NUM_SLOTS-1:0] hit;
	logic [NUM_SLOTS-1:0] free;
	logic [NUM_SLOTS-1:0] first_hit;
	logic [NUM_SLOTS-1:0] first_free;
	logic [7:0]           byte_sel;
	logic [IDX_W-1:0]     slot_off;
	logic [SLOT_W-1:0]    slot_sel;

	always_comb begin
		logic seen_hit;
		logic seen_free;
		seen_hit  = 1'b0;
		seen_free = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hit[i]        = (slots_q[i] == usage_q);
			free[i]       = (slots_q[i] == 8'h00);
			first_hit[i]  = hit[i] && !seen_hit;
			first_free[i] = free[i] && !seen_free;
			seen_hit      = seen_hit | hit[i];
			seen_free     = seen_free | free[i];
		end
	end

	assign slot_off = cmd.idx - IDX_SLOT0;
	assign slot_sel = slot_off[SLOT_W-1:0];

	always_comb begin
		case (cmd.idx)
			IDX_SYNC_A:  byte_sel = SYNC_A;
			IDX_SYNC_B:  byte_sel = SYNC_B;
			IDX_MOD:     byte_sel = mod_q;
			IDX_RSVD:    byte_sel = 8'h00;
			IDX_TRAILER: byte_sel = TRAILER;
			IDX_CRC:     byte_sel = crc_q;
			default:     byte_sel = slots_q[slot_sel];
		endcase
	end

	assign status.frame_needed = (mod_q != 8'h00) || (slots_q[0] != 8'h00);
	assign status.out_free     = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last       = last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_mod_q  <= is_modifier;
			bit_q     <= modifier_bit;
			usage_q   <= usage;
			pressed_q <= pressed;
		end
		if (cmd.load) begin
			frame_byte_q <= byte_sel;
			last_q       <= (cmd.idx == IDX_CRC);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.crc_clr) begin
			crc_q <= 8'h00;
		end else if (cmd.load && cmd.idx != IDX_CRC) begin
			crc_q <= crc_byte(crc_q, byte_sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= 8'h00;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slots_q[i] <= 8'h00;
			end
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.update) begin
				if (is_mod_q) begin
					if (pressed_q) begin
						mod_q <= mod_q | (8'h01 << bit_q);
					end else begin
						mod_q <= mod_q & ~(8'h01 << bit_q);
					end
				end else if (usage_q != 8'h00) begin
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (pressed_q) begin
							if (hit == '0 && first_free[i]) begin
								slots_q[i] <= usage_q;
							end
						end else if (first_hit[i]) begin
							slots_q[i] <= 8'h00;
						end
					end
				end
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while held");

	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !is_mod_q && pressed_q && usage_q != 8'h00)
		|=> $countones(hit) <= 1)
		else $error("usage present in more than one slot");

	a_crc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.crc_clr) |-> crc_q == 8'h00)
		else $error("crc not cleared at frame start");

endmodule

FILE: src/hid_key_report_framer.sv
// Top level of the boot-keyboard report framer with CRC-8 frame trailer.
// An item passes the update and check states before its first byte is loaded.
// Throughput: one byte a cycle while the output is not stalled, 12 bytes per frame;
//   an item that yields no frame frees the input after the check state; otherwise
//   the next item waits until the frame's last byte is in the output register.
// Reset: arst_n clears the modifier byte, all six key slots and the output valid.
module hid_key_report_framer (
	input  logic       clk,
	input  logic       arst_n,
	// Event channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       is_modifier,
	input  logic [2:0] modifier_bit,
	input  logic [7:0] usage,
	input  logic       pressed,
	// Frame byte channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       last
);
	import hkrf_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence: capture the item, apply it to the report, check the frame gate
	// (modifier byte or first slot nonzero), then stream the bytes while the
	// CRC accumulates behind them.
	hkrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold the report and the output register; the output register lets a
	// finished byte wait under stall while the next byte is prepared.
	hkrf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.is_modifier  (is_modifier),
		.modifier_bit (modifier_bit),
		.usage        (usage),
		.pressed      (pressed),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.frame_byte   (frame_byte),
		.last         (last)
	);

endmodule

FILE: test/tb_hid_key_report_framer.sv
// Self-checking testbench for the key report framer: key events in, checked frame bytes out.
module tb_hid_key_report_framer;
	import hkrf_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 360;
	localparam int IDLE_PCT     = 34;
	localparam int HOLD_CYCLES  = 160;   // long receiver hold-off, enough to back up the input
	localparam int HOLD_AT      = 60;    // items offered before the hold-off starts
	localparam int CALM_FROM    = 150;   // window of items with no idling on either side
	localparam int CALM_TO      = 230;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_REPORTS  = 10;
	localparam int LIMIT_CYCLES = 400000;
	localparam int POOL_SIZE    = 8;

	// One key event as offered on the event channel
	typedef struct packed {
		logic       is_mod;
		logic [2:0] mod_pos;
		logic [7:0] usage;
		logic       pressed;
	} key_event_t;

	// One frame byte as expected on the output channel
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       is_modifier  = 1'b0;
	logic [2:0] modifier_bit = 3'd0;
	logic [7:0] usage        = 8'd0;
	logic       pressed      = 1'b0;
	logic       out_stall    = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] frame_byte;
	logic       last;

	key_event_t  event_q[$];        // events waiting to be offered
	frame_beat_t frame_q[$];        // frame bytes the block still owes
	logic        ev_taken    = 1'b0;
	int          events_sent = 0;
	int          hold_left   = 0;
	logic        hold_done   = 1'b0;
	int          err_cnt     = 0;
	logic        calm;

	// Local copy of the report state
	logic [7:0] mod_state;
	logic [7:0] slot_state [NUM_SLOTS];

	hid_key_report_framer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.is_modifier  (is_modifier),
		.modifier_bit (modifier_bit),
		.usage        (usage),
		.pressed      (pressed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_byte   (frame_byte),
		.last         (last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Suspend idling on both sides for a stretch of the random part
	assign calm = (events_sent >= CALM_FROM) && (events_sent < CALM_TO);

	// Advance the CRC-8 (poly 0x07, init 0, MSB first) by one byte
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Apply one accepted key event to the local report and queue the frame it causes
	task automatic apply_key_event(input logic is_mod, input logic [2:0] pos,
			input logic [7:0] u, input logic down);
		logic [7:0]  frame [FRAME_BYTES];
		logic [7:0]  crc;
		logic        found;
		frame_beat_t beat;
		found = 1'b0;
		if (is_mod) begin
			// usage is ignored for modifier events
			if (down)
				mod_state = mod_state | (8'h01 << pos);
			else
				mod_state = mod_state & ~(8'h01 << pos);
		end else if (u != 8'h00) begin
			// modifier_bit is ignored for ordinary keys; usage 0 changes nothing
			if (down) begin
				// drop a press that is already present, or that finds no free slot
				for (int i = 0; i < NUM_SLOTS; i++)
					if (slot_state[i] == u)
						found = 1'b1;
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!found && slot_state[i] == 8'h00) begin
						slot_state[i] = u;
						found = 1'b1;
					end
			end else begin
				// clear only the first matching slot; an absent usage changes nothing
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!found && slot_state[i] == u) begin
						slot_state[i] = 8'h00;
						found = 1'b1;
					end
			end
		end
		// No frame while modifiers and the first slot are clear, even with later slots held
		if (mod_state == 8'h00 && slot_state[0] == 8'h00)
			return;
		frame[0] = SYNC_A;
		frame[1] = SYNC_B;
		frame[2] = mod_state;
		frame[3] = 8'h00;
		for (int i = 0; i < NUM_SLOTS; i++)
			frame[4 + i] = slot_state[i];
		frame[FRAME_BYTES - 2] = TRAILER;
		crc = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			crc = crc8_next(crc, frame[i]);
		frame[FRAME_BYTES - 1] = crc;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			beat.data = frame[i];
			beat.last = (i == FRAME_BYTES - 1);
			frame_q.push_back(beat);
		end
	endtask

	function automatic void queue_event(input logic is_mod, input logic [2:0] pos,
			input logic [7:0] u, input logic down);
		key_event_t ev;
		ev.is_mod  = is_mod;
		ev.mod_pos = pos;
		ev.usage   = u;
		ev.pressed = down;
		event_q.push_back(ev);
	endfunction

	// Sender: change inputs at the falling edge; hold an offered item until it is taken
	always @(negedge clk) begin : drive_events
		key_event_t ev;
		logic       idle_now;
		// keep offering during the receiver hold-off so the block backs up
		idle_now = !calm && (hold_left == 0) && ($urandom_range(99) < IDLE_PCT);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !ev_taken) begin
			// hold valid and payload while stalled
		end else if (event_q.size() != 0 && !idle_now) begin
			ev = event_q.pop_front();
			in_valid     <= 1'b1;
			is_modifier  <= ev.is_mod;
			modifier_bit <= ev.mod_pos;
			usage        <= ev.usage;
			pressed      <= ev.pressed;
			events_sent  <= events_sent + 1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here in cycles
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && events_sent >= HOLD_AT) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Sample both channels at the rising edge: predict on input, check on output
	always @(posedge clk) begin : check_frames
		frame_beat_t want;
		if (!arst_n) begin
			ev_taken <= 1'b0;
		end else begin
			ev_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				apply_key_event(is_modifier, modifier_bit, usage, pressed);
			if (out_valid && !out_stall) begin
				if (frame_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("unexpected frame byte %02h last %0b", frame_byte, last);
				end else begin
					want = frame_q.pop_front();
					if (frame_byte !== want.data || last !== want.last) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
								want.data, want.last, frame_byte, last);
					end
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [7:0] pool [POOL_SIZE];
		int         n;
		int         pick;
		mod_state = 8'h00;
		for (int i = 0; i < NUM_SLOTS; i++)
			slot_state[i] = 8'h00;

		// Directed part
		queue_event(1'b0, 3'd7, 8'h00, 1'b1);   // usage zero from reset: no frame
		queue_event(1'b0, 3'd0, 8'h00, 1'b0);
		queue_event(1'b1, 3'd0, 8'hFF, 1'b1);   // modifier event ignores usage
		queue_event(1'b1, 3'd7, 8'h00, 1'b1);
		queue_event(1'b1, 3'd0, 8'h00, 1'b0);
		queue_event(1'b1, 3'd7, 8'h00, 1'b0);   // all clear again: no frame
		queue_event(1'b0, 3'd5, 8'h04, 1'b1);   // ordinary event ignores modifier_bit
		queue_event(1'b0, 3'd0, 8'h04, 1'b1);   // already present
		queue_event(1'b0, 3'd0, 8'hFF, 1'b1);
		queue_event(1'b0, 3'd0, 8'h01, 1'b1);
		queue_event(1'b0, 3'd0, 8'h80, 1'b1);
		queue_event(1'b0, 3'd0, 8'h55, 1'b1);
		queue_event(1'b0, 3'd0, 8'hAA, 1'b1);   // last free slot
		queue_event(1'b0, 3'd0, 8'h10, 1'b1);   // all slots full: dropped
		queue_event(1'b0, 3'd0, 8'h99, 1'b0);   // release of an absent usage
		queue_event(1'b0, 3'd0, 8'h04, 1'b0);   // first slot empty, later held: no frame
		queue_event(1'b0, 3'd0, 8'h3C, 1'b1);   // refills the first slot
		queue_event(1'b0, 3'd0, 8'hFF, 1'b0);
		queue_event(1'b0, 3'd0, 8'h01, 1'b0);
		queue_event(1'b0, 3'd0, 8'h80, 1'b0);
		queue_event(1'b0, 3'd0, 8'h55, 1'b0);
		queue_event(1'b0, 3'd0, 8'hAA, 1'b0);
		queue_event(1'b0, 3'd0, 8'h3C, 1'b0);
		queue_event(1'b1, 3'd3, 8'h33, 1'b1);
		queue_event(1'b1, 3'd3, 8'h00, 1'b0);

		// Random part: mostly press/release of a small usage pool so that slots
		// fill, match and empty; some modifier traffic, some full-range noise,
		// and now and then a release sweep of every pool usage and every modifier bit.
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = 8'($urandom_range(255, 1));
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				for (int i = 0; i < POOL_SIZE; i++)
					queue_event(1'b0, 3'($urandom_range(7)), pool[i], 1'b0);
				for (int i = 0; i < 8; i++)
					queue_event(1'b1, 3'(i), 8'($urandom_range(255)), 1'b0);
				n += POOL_SIZE + 8;
			end else if (pick < 28) begin
				queue_event(1'b1, 3'($urandom_range(7)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				n++;
			end else if (pick < 88) begin
				queue_event(1'b0, 3'($urandom_range(7)), pool[$urandom_range(POOL_SIZE - 1)],
					$urandom_range(99) < 55);
				n++;
			end else begin
				queue_event(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
				n++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all items taken, all frame bytes seen, then let the block settle
		while (event_q.size() != 0 || in_valid)
			@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_hid_key_report_framer: PASS");
		else
			$display("tb_hid_key_report_framer: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("tb_hid_key_report_framer: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
src/hkrf_pkg.sv
src/hkrf_ctrl.sv
src/hkrf_dp.sv
src/hid_key_report_framer.sv
test/tb_hid_key_report_framer.sv
